/* sv/fbpp_pkg.sv */
// fbpp_pkg: widths, reset values, codes and controller/datapath types for the
// frame store pixel plotter. No dependencies; every other file uses it.
package fbpp_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;

  localparam int FuncW    = 2;
  localparam int CoordW   = 11;
  localparam int ColorW   = 8;
  localparam int AreaW    = 9;
  localparam int LineW    = 8;
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 5;

  localparam logic [ColorW-1:0] FillAtReset     = 8'hFF;
  localparam logic [ColorW-1:0] DrawColorRst    = 8'h00;
  localparam logic [ColorW-1:0] BgColorRst      = 8'hFF;
  localparam logic [AreaW-1:0]  ActiveWidthRst  = 9'd256;
  localparam logic [AreaW-1:0]  ActiveHeightRst = 9'd256;

  typedef enum logic [FuncW-1:0] {
    FUNC_SET   = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_DIRTY = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_DRAW_COLOR    = 3'd0,
    REG_XOR_MODE      = 3'd1,
    REG_BG_COLOR      = 3'd2,
    REG_ACTIVE_WIDTH  = 3'd3,
    REG_ACTIVE_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PLAIN,
    WR_XOR,
    WR_FILL
  } wr_kind_e;

  typedef enum logic [1:0] {
    DOP_NONE,
    DOP_MARK,
    DOP_ALL,
    DOP_TAKE
  } dirty_op_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ZERO,
    RES_PIXEL,
    RES_DIRTY
  } res_op_e;

  typedef struct packed {
    logic [ColorW-1:0] draw_color;
    logic              xor_mode;
    logic [ColorW-1:0] background_color;
    logic [AreaW-1:0]  active_width;
    logic [AreaW-1:0]  active_height;
  } cfg_t;

  typedef struct packed {
    logic      latch_item;
    logic      decode;
    logic      mem_rd;
    wr_kind_e  wr_kind;
    logic      sweep_start;
    dirty_op_e dirty_op;
    res_op_e   res_op;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  in_canvas;
    logic  xor_mode;
    logic  sweep_last;
    logic  out_free;
  } sts_t;

endpackage

/* sv/fbpp_req_if.sv */
// fbpp_req_if: request channel (valid/ready plus func, x, y)
// depends on fbpp_pkg for field widths
interface fbpp_req_if;
  logic                               valid;
  logic                               ready;
  logic        [fbpp_pkg::FuncW-1:0]  func;
  logic signed [fbpp_pkg::CoordW-1:0] x;
  logic signed [fbpp_pkg::CoordW-1:0] y;

  modport source (output valid, func, x, y, input ready);
  modport sink   (input valid, func, x, y, output ready);
endinterface

/* sv/fbpp_rsp_if.sv */
// fbpp_rsp_if: result channel (valid/ready plus pixel and dirty range fields)
// depends on fbpp_pkg for field widths
interface fbpp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fbpp_pkg::ColorW-1:0]   pixel_value;
  logic                          pixel_valid;
  logic                          dirty_any;
  logic [fbpp_pkg::LineW-1:0]    dirty_first_line;
  logic [fbpp_pkg::LineW-1:0]    dirty_last_line;

  modport source (output valid, pixel_value, pixel_valid, dirty_any, dirty_first_line,
                  dirty_last_line, input ready);
  modport sink   (input valid, pixel_value, pixel_valid, dirty_any, dirty_first_line,
                  dirty_last_line, output ready);
endinterface

/* sv/fbpp_regs.sv */
// fbpp_regs: APB-style configuration registers (draw color, xor mode,
// background color, active area). Depends on fbpp_pkg.
module fbpp_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fbpp_pkg::CfgAddrW-1:0]     paddr,
  input  logic [fbpp_pkg::CfgDataW-1:0]     pwdata,
  output logic [fbpp_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready,
  output fbpp_pkg::cfg_t                    cfg_o
);

  fbpp_pkg::cfg_t     cfg_q, cfg_d;
  fbpp_pkg::cfg_reg_e reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = fbpp_pkg::cfg_reg_e'(paddr[fbpp_pkg::CfgAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        fbpp_pkg::REG_DRAW_COLOR:    cfg_d.draw_color       = pwdata[fbpp_pkg::ColorW-1:0];
        fbpp_pkg::REG_XOR_MODE:      cfg_d.xor_mode         = pwdata[0];
        fbpp_pkg::REG_BG_COLOR:      cfg_d.background_color = pwdata[fbpp_pkg::ColorW-1:0];
        fbpp_pkg::REG_ACTIVE_WIDTH:  cfg_d.active_width     = pwdata[fbpp_pkg::AreaW-1:0];
        fbpp_pkg::REG_ACTIVE_HEIGHT: cfg_d.active_height    = pwdata[fbpp_pkg::AreaW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fbpp_pkg::REG_DRAW_COLOR:    prdata = fbpp_pkg::CfgDataW'(cfg_q.draw_color);
      fbpp_pkg::REG_XOR_MODE:      prdata = fbpp_pkg::CfgDataW'(cfg_q.xor_mode);
      fbpp_pkg::REG_BG_COLOR:      prdata = fbpp_pkg::CfgDataW'(cfg_q.background_color);
      fbpp_pkg::REG_ACTIVE_WIDTH:  prdata = fbpp_pkg::CfgDataW'(cfg_q.active_width);
      fbpp_pkg::REG_ACTIVE_HEIGHT: prdata = fbpp_pkg::CfgDataW'(cfg_q.active_height);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.draw_color       <= fbpp_pkg::DrawColorRst;
      cfg_q.xor_mode         <= 1'b0;
      cfg_q.background_color <= fbpp_pkg::BgColorRst;
      cfg_q.active_width     <= fbpp_pkg::ActiveWidthRst;
      cfg_q.active_height    <= fbpp_pkg::ActiveHeightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/fbpp_ctrl.sv */
// fbpp_ctrl: sequencing state machine; issues commands to fbpp_dp and
// watches its status. Depends on fbpp_pkg.
module fbpp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fbpp_pkg::sts_t sts_i,
  output fbpp_pkg::cmd_t cmd_o
);

  fbpp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbpp_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    cmd_o.latch_item   = 1'b0;
    cmd_o.decode       = 1'b0;
    cmd_o.mem_rd       = 1'b0;
    cmd_o.wr_kind      = fbpp_pkg::WR_NONE;
    cmd_o.sweep_start  = 1'b0;
    cmd_o.dirty_op     = fbpp_pkg::DOP_NONE;
    cmd_o.res_op       = fbpp_pkg::RES_NONE;
    cmd_o.out_load     = 1'b0;

    unique case (state_q)
      // power-up fill of the frame store
      fbpp_pkg::ST_INIT: begin
        cmd_o.wr_kind = fbpp_pkg::WR_FILL;
        if (sts_i.sweep_last) begin
          state_d = fbpp_pkg::ST_IDLE;
        end
      end
      fbpp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = fbpp_pkg::ST_DECODE;
        end
      end
      fbpp_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = fbpp_pkg::ST_EXEC;
      end
      fbpp_pkg::ST_EXEC: begin
        unique case (sts_i.func)
          fbpp_pkg::FUNC_SET: begin
            if (sts_i.in_canvas) begin
              cmd_o.dirty_op = fbpp_pkg::DOP_MARK;
              if (sts_i.xor_mode) begin
                cmd_o.mem_rd = 1'b1;
                state_d      = fbpp_pkg::ST_READ;
              end else begin
                cmd_o.wr_kind = fbpp_pkg::WR_PLAIN;
                cmd_o.res_op  = fbpp_pkg::RES_ZERO;
                state_d       = fbpp_pkg::ST_RESP;
              end
            end else begin
              cmd_o.res_op = fbpp_pkg::RES_ZERO;
              state_d      = fbpp_pkg::ST_RESP;
            end
          end
          fbpp_pkg::FUNC_GET: begin
            if (sts_i.in_canvas) begin
              cmd_o.mem_rd = 1'b1;
              state_d      = fbpp_pkg::ST_READ;
            end else begin
              cmd_o.res_op = fbpp_pkg::RES_ZERO;
              state_d      = fbpp_pkg::ST_RESP;
            end
          end
          fbpp_pkg::FUNC_CLEAR: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.dirty_op    = fbpp_pkg::DOP_ALL;
            cmd_o.res_op      = fbpp_pkg::RES_ZERO;
            state_d           = fbpp_pkg::ST_SWEEP;
          end
          fbpp_pkg::FUNC_DIRTY: begin
            cmd_o.res_op   = fbpp_pkg::RES_DIRTY;
            cmd_o.dirty_op = fbpp_pkg::DOP_TAKE;
            state_d        = fbpp_pkg::ST_RESP;
          end
        endcase
      end
      // read data is registered, use it in the cycle after the read
      fbpp_pkg::ST_READ: begin
        if (sts_i.func == fbpp_pkg::FUNC_SET) begin
          cmd_o.wr_kind = fbpp_pkg::WR_XOR;
          cmd_o.res_op  = fbpp_pkg::RES_ZERO;
        end else begin
          cmd_o.res_op = fbpp_pkg::RES_PIXEL;
        end
        state_d = fbpp_pkg::ST_RESP;
      end
      fbpp_pkg::ST_SWEEP: begin
        cmd_o.wr_kind = fbpp_pkg::WR_FILL;
        if (sts_i.sweep_last) begin
          state_d = fbpp_pkg::ST_RESP;
        end
      end
      fbpp_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = fbpp_pkg::ST_IDLE;
        end
      end
      default: state_d = fbpp_pkg::ST_INIT;
    endcase
  end

endmodule

/* sv/fbpp_dp.sv */
// fbpp_dp: clipping, address generation, frame store memory, fill sweep,
// dirty line range and result/output registers. Depends on fbpp_pkg.
module fbpp_dp #(
  parameter int MAX_WIDTH  = fbpp_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = fbpp_pkg::MaxHeightDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fbpp_pkg::cfg_t                     cfg_i,
  input  fbpp_pkg::cmd_t                     cmd_i,
  output fbpp_pkg::sts_t                     sts_o,
  input  logic        [fbpp_pkg::FuncW-1:0]  func_i,
  input  logic signed [fbpp_pkg::CoordW-1:0] x_i,
  input  logic signed [fbpp_pkg::CoordW-1:0] y_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic        [fbpp_pkg::ColorW-1:0] pixel_value_o,
  output logic                               pixel_valid_o,
  output logic                               dirty_any_o,
  output logic        [fbpp_pkg::LineW-1:0]  dirty_first_line_o,
  output logic        [fbpp_pkg::LineW-1:0]  dirty_last_line_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WSzW  = $clog2(MAX_WIDTH + 1);
  localparam int HSzW  = $clog2(MAX_HEIGHT + 1);
  localparam int CmpA  = (WSzW > HSzW) ? WSzW : HSzW;
  localparam int CmpB  = (fbpp_pkg::AreaW > fbpp_pkg::CoordW - 1) ?
                         fbpp_pkg::AreaW : fbpp_pkg::CoordW - 1;
  localparam int CmpW  = (CmpA > CmpB) ? CmpA : CmpB;
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int HRst  = (int'(fbpp_pkg::ActiveHeightRst) > MAX_HEIGHT) ?
                         MAX_HEIGHT : int'(fbpp_pkg::ActiveHeightRst);

  // item registers
  fbpp_pkg::func_e                   func_q;
  logic signed [fbpp_pkg::CoordW-1:0] x_q, y_q;
  logic                              inside_q;
  logic [AW-1:0]                     addr_q;
  logic [YW-1:0]                     line_q;

  // clipping
  logic [CmpW-1:0] aw_ext, ah_ext, eff_w, eff_h, x_ext, y_ext;
  logic            inside_d;
  logic [AW-1:0]   addr_d;

  assign aw_ext = CmpW'(cfg_i.active_width);
  assign ah_ext = CmpW'(cfg_i.active_height);
  assign eff_w  = (aw_ext == '0) ? CmpW'(1) :
                  (aw_ext > CmpW'(MAX_WIDTH)) ? CmpW'(MAX_WIDTH) : aw_ext;
  assign eff_h  = (ah_ext == '0) ? CmpW'(1) :
                  (ah_ext > CmpW'(MAX_HEIGHT)) ? CmpW'(MAX_HEIGHT) : ah_ext;
  assign x_ext  = CmpW'(x_q[fbpp_pkg::CoordW-2:0]);
  assign y_ext  = CmpW'(y_q[fbpp_pkg::CoordW-2:0]);

  assign inside_d = !x_q[fbpp_pkg::CoordW-1] && !y_q[fbpp_pkg::CoordW-1] &&
                    (x_ext < eff_w) && (y_ext < eff_h);
  // row-major address, constant stride
  assign addr_d   = AW'(y_ext[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x_ext[XW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      func_q <= fbpp_pkg::func_e'(func_i);
      x_q    <= x_i;
      y_q    <= y_i;
    end
    if (cmd_i.decode) begin
      inside_q <= inside_d;
      addr_q   <= addr_d;
      line_q   <= y_ext[YW-1:0];
    end
  end

  // fill sweep
  logic [AW-1:0]               sweep_cnt_q;
  logic [fbpp_pkg::ColorW-1:0] fill_q;
  logic                        sweep_last;

  assign sweep_last = (sweep_cnt_q == AW'(Depth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      fill_q      <= fbpp_pkg::FillAtReset;
    end else if (cmd_i.sweep_start) begin
      sweep_cnt_q <= '0;
      fill_q      <= cfg_i.background_color;
    end else if (cmd_i.wr_kind == fbpp_pkg::WR_FILL) begin
      sweep_cnt_q <= sweep_cnt_q + AW'(1);
    end
  end

  // frame store
  logic [fbpp_pkg::ColorW-1:0] mem_q [Depth];
  logic [fbpp_pkg::ColorW-1:0] rdata_q;
  logic [fbpp_pkg::ColorW-1:0] mem_wdata;
  logic [AW-1:0]               mem_waddr;
  logic                        mem_we;

  assign mem_we    = (cmd_i.wr_kind != fbpp_pkg::WR_NONE);
  assign mem_waddr = (cmd_i.wr_kind == fbpp_pkg::WR_FILL) ? sweep_cnt_q : addr_q;

  always_comb begin
    unique case (cmd_i.wr_kind)
      fbpp_pkg::WR_PLAIN: mem_wdata = cfg_i.draw_color;
      fbpp_pkg::WR_XOR:   mem_wdata = rdata_q ^ cfg_i.draw_color;
      fbpp_pkg::WR_FILL:  mem_wdata = fill_q;
      fbpp_pkg::WR_NONE:  mem_wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // dirty line range, empty when min > max
  logic [HSzW-1:0] dirty_min_q;
  logic [YW-1:0]   dirty_max_q;
  logic            dirty_any;

  assign dirty_any = (CmpW'(dirty_min_q) <= CmpW'(dirty_max_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_min_q <= HSzW'(HRst);
      dirty_max_q <= '0;
    end else begin
      unique case (cmd_i.dirty_op)
        fbpp_pkg::DOP_MARK: begin
          if (line_q > dirty_max_q) begin
            dirty_max_q <= line_q;
          end
          if (HSzW'(line_q) < dirty_min_q) begin
            dirty_min_q <= HSzW'(line_q);
          end
        end
        fbpp_pkg::DOP_ALL: begin
          dirty_min_q <= '0;
          dirty_max_q <= YW'(eff_h - CmpW'(1));
        end
        fbpp_pkg::DOP_TAKE: begin
          dirty_min_q <= HSzW'(eff_h);
          dirty_max_q <= '0;
        end
        fbpp_pkg::DOP_NONE: ;
      endcase
    end
  end

  // pending result
  logic [fbpp_pkg::ColorW-1:0] res_value_q;
  logic                        res_pvalid_q, res_any_q;
  logic [fbpp_pkg::LineW-1:0]  res_first_q, res_last_q;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res_op)
      fbpp_pkg::RES_ZERO: begin
        res_value_q  <= '0;
        res_pvalid_q <= 1'b0;
        res_any_q    <= 1'b0;
        res_first_q  <= '0;
        res_last_q   <= '0;
      end
      fbpp_pkg::RES_PIXEL: begin
        res_value_q  <= rdata_q;
        res_pvalid_q <= 1'b1;
        res_any_q    <= 1'b0;
        res_first_q  <= '0;
        res_last_q   <= '0;
      end
      fbpp_pkg::RES_DIRTY: begin
        res_value_q  <= '0;
        res_pvalid_q <= 1'b0;
        res_any_q    <= dirty_any;
        res_first_q  <= dirty_any ? fbpp_pkg::LineW'(dirty_min_q) : '0;
        res_last_q   <= dirty_any ? fbpp_pkg::LineW'(dirty_max_q) : '0;
      end
      fbpp_pkg::RES_NONE: ;
    endcase
  end

  // output register
  logic out_valid_q, out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_value_o      <= res_value_q;
      pixel_valid_o      <= res_pvalid_q;
      dirty_any_o        <= res_any_q;
      dirty_first_line_o <= res_first_q;
      dirty_last_line_o  <= res_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.func        = func_q;
  assign sts_o.in_canvas   = inside_q;
  assign sts_o.xor_mode    = cfg_i.xor_mode;
  assign sts_o.sweep_last  = sweep_last;
  assign sts_o.out_free    = out_free;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result loaded over an unread word");

  a_take_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dirty_op == fbpp_pkg::DOP_TAKE |=> !dirty_any)
    else $error("dirty range not empty after take");

  a_pix_wr_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_kind == fbpp_pkg::WR_PLAIN || cmd_i.wr_kind == fbpp_pkg::WR_XOR) |-> inside_q)
    else $error("pixel write outside the canvas");

  a_pix_res_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_op == fbpp_pkg::RES_PIXEL |-> inside_q && $past(cmd_i.mem_rd))
    else $error("pixel result without a read");

endmodule

/* sv/framebuffer_pixel_plotter.sv */
// framebuffer_pixel_plotter: top level of the clipped 8-bit frame store.
// Depends on fbpp_pkg, fbpp_req_if, fbpp_rsp_if, fbpp_regs, fbpp_ctrl, fbpp_dp.
//
//   channel | dir | handshake              | word
//   req_i   | in  | valid/ready            | func, x, y
//   rsp_o   | out | valid/ready            | pixel_value, pixel_valid, dirty_any,
//           |     |                        | dirty_first_line, dirty_last_line
//   apb     | in  | psel/penable, pready=1 | 5 registers at 4*i
//
// one word in flight; each word passes through decode and execute states and then a
// response state, set in xor mode and get inside the canvas also through a read state
// (registered read of the frame store), clear through a sweep (one write per cycle)
// after reset a fill pass over all MAX_WIDTH*MAX_HEIGHT words writes 255 everywhere;
// no word is accepted until it ends, register writes are taken throughout
// while rsp_o is stalled the result word holds and the block waits in its response state
module framebuffer_pixel_plotter #(
  parameter int MAX_WIDTH  = fbpp_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = fbpp_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbpp_pkg::CfgAddrW-1:0] paddr,
  input  logic [fbpp_pkg::CfgDataW-1:0] pwdata,
  output logic [fbpp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  fbpp_req_if.sink                      req_i,
  fbpp_rsp_if.source                    rsp_o
);

  fbpp_pkg::cfg_t cfg;
  fbpp_pkg::cmd_t cmd;
  fbpp_pkg::sts_t sts;
  logic           in_ready;

  fbpp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fbpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbpp_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .func_i             (req_i.func),
    .x_i                (req_i.x),
    .y_i                (req_i.y),
    .out_ready_i        (rsp_o.ready),
    .out_valid_o        (rsp_o.valid),
    .pixel_value_o      (rsp_o.pixel_value),
    .pixel_valid_o      (rsp_o.pixel_valid),
    .dirty_any_o        (rsp_o.dirty_any),
    .dirty_first_line_o (rsp_o.dirty_first_line),
    .dirty_last_line_o  (rsp_o.dirty_last_line)
  );

  assign req_i.ready = in_ready;

endmodule
